[hdl/gadm_pkg.sv]
// shared types, constants and codes for the gamepad axis deadzone mapper
package gadm_pkg;

   // field widths
   localparam int FRAC_BITS = 15;
   localparam int RAW_W     = 16;
   localparam int AXIS_W    = 8;
   localparam int DZ_W      = 15;
   localparam int STICK_W   = 16;
   localparam int TRIG_W    = 15;
   localparam int DPAD_W    = 4;
   localparam int NUM_AXES  = 6;
   localparam int AIDX_W    = 3;

   // rescale arithmetic: numerator = excess * full_scale + den / 2
   localparam int NUM_W = RAW_W + FRAC_BITS + 1;
   // quotient is below 2^(FRAC_BITS + 2) because excess <= den + 1
   localparam int QUO_W = FRAC_BITS + 2;
   localparam int REM_W = DZ_W + 1;
   localparam int CNT_W = $clog2(QUO_W);

   localparam logic [FRAC_BITS-1:0] FULL_SCALE = {FRAC_BITS{1'b1}};
   localparam logic [DZ_W-1:0]      RAW_FULL   = {DZ_W{1'b1}};

   // configuration defaults
   localparam logic [DZ_W-1:0] STICK_DZ_RESET = 15'd8000;
   localparam logic [DZ_W-1:0] TRIG_DZ_RESET  = 15'd400;

   // configuration register map
   localparam int               CSR_ADDR_W     = 3;
   localparam int               CSR_DATA_W     = 32;
   localparam logic [CSR_ADDR_W-1:0] ADDR_STICK_DZ = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] ADDR_TRIG_DZ  = 3'd4;

   // axis numbers
   localparam logic [AXIS_W-1:0] AXIS_LEFT_X   = 8'd0;
   localparam logic [AXIS_W-1:0] AXIS_LEFT_Y   = 8'd1;
   localparam logic [AXIS_W-1:0] AXIS_LEFT_TRG = 8'd2;
   localparam logic [AXIS_W-1:0] AXIS_RIGHT_X  = 8'd3;
   localparam logic [AXIS_W-1:0] AXIS_RIGHT_Y  = 8'd4;
   localparam logic [AXIS_W-1:0] AXIS_RIGHT_TRG = 8'd5;
   localparam logic [AXIS_W-1:0] AXIS_DPAD_H   = 8'd6;
   localparam logic [AXIS_W-1:0] AXIS_DPAD_V   = 8'd7;

   // d-pad bits
   localparam logic [DPAD_W-1:0] DPAD_LEFT  = 4'b0001;
   localparam logic [DPAD_W-1:0] DPAD_RIGHT = 4'b0010;
   localparam logic [DPAD_W-1:0] DPAD_UP    = 4'b0100;
   localparam logic [DPAD_W-1:0] DPAD_DOWN  = 4'b1000;

   typedef enum logic [2:0] {
      KIND_NONE,
      KIND_STICK,
      KIND_TRIG,
      KIND_DPAD_H,
      KIND_DPAD_V
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_MUL,
      ST_SETUP,
      ST_DIV,
      ST_COMMIT,
      ST_PUBLISH
   } state_type;

   typedef struct packed {
      logic load;
      logic prep;
      logic mul;
      logic setup;
      logic div_step;
      logic commit;
      logic publish;
   } dp_cmd_type;

   typedef struct packed {
      logic need_div;
      logic div_last;
   } dp_status_type;

   typedef struct packed {
      logic [DZ_W-1:0] stick_dz;
      logic [DZ_W-1:0] trig_dz;
   } cfg_type;

   typedef struct packed {
      logic [DPAD_W-1:0]  dpad_bits;
      logic [TRIG_W-1:0]  right_trigger_level;
      logic [STICK_W-1:0] right_stick_y;
      logic [STICK_W-1:0] right_stick_x;
      logic [TRIG_W-1:0]  left_trigger_level;
      logic [STICK_W-1:0] left_stick_y;
      logic [STICK_W-1:0] left_stick_x;
   } snapshot_type;

endpackage

[hdl/gadm_ctrl.sv]
// sequencer for one event: decode, multiply, serial divide, commit, publish
module gadm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   out_free,
   input  gadm_pkg::dp_status_type status,
   output logic                   req_tready,
   output gadm_pkg::dp_cmd_type    cmd
);

   gadm_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gadm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         gadm_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = gadm_pkg::ST_PREP;
            end
         end
         gadm_pkg::ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = gadm_pkg::ST_MUL;
         end
         gadm_pkg::ST_MUL: begin
            cmd.mul = 1'b1;
            if (status.need_div) begin
               state_in = gadm_pkg::ST_SETUP;
            end else begin
               state_in = gadm_pkg::ST_COMMIT;
            end
         end
         gadm_pkg::ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = gadm_pkg::ST_DIV;
         end
         gadm_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = gadm_pkg::ST_COMMIT;
            end
         end
         gadm_pkg::ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = gadm_pkg::ST_PUBLISH;
         end
         gadm_pkg::ST_PUBLISH: begin
            if (out_free) begin
               cmd.publish = 1'b1;
               state_in    = gadm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gadm_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

[hdl/gadm_datapath.sv]
// event decode, deadzone, rescale multiply, restoring divider and held axis state
module gadm_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  gadm_pkg::dp_cmd_type             cmd,
   input  gadm_pkg::cfg_type                cfg,
   input  logic                             in_is_axis,
   input  logic [gadm_pkg::AXIS_W-1:0]      in_axis,
   input  logic [gadm_pkg::RAW_W-1:0]       in_raw,
   output gadm_pkg::dp_status_type          status,
   output gadm_pkg::snapshot_type           snapshot
);

   // captured word
   logic                            is_axis_ff;
   logic [gadm_pkg::AXIS_W-1:0]     axis_ff;
   logic [gadm_pkg::RAW_W-1:0]      raw_ff;

   // decoded operands
   gadm_pkg::kind_type              kind_ff, kind_in;
   logic                            live_ff, live_in;
   logic                            neg_ff;
   logic [gadm_pkg::RAW_W-1:0]      excess_ff, excess_in;
   logic [gadm_pkg::DZ_W-1:0]       den_ff, den_in;

   // divider
   logic [gadm_pkg::NUM_W-1:0]      num_ff;
   logic [gadm_pkg::REM_W-1:0]      rem_ff, rem_in;
   logic [gadm_pkg::QUO_W-1:0]      quo_ff, quo_in;
   logic [gadm_pkg::CNT_W-1:0]      cnt_ff, cnt_in;
   logic [gadm_pkg::REM_W-1:0]      trial;
   logic                            qbit;

   // held state
   logic [gadm_pkg::STICK_W-1:0]    axis_val_ff [gadm_pkg::NUM_AXES];
   logic [gadm_pkg::DPAD_W-1:0]     dpad_ff, dpad_in;

   // commit value
   logic [gadm_pkg::FRAC_BITS-1:0]  q_sat;
   logic [gadm_pkg::STICK_W-1:0]    q_mag;
   logic [gadm_pkg::STICK_W-1:0]    new_val;

   logic [gadm_pkg::RAW_W-1:0]      mag;
   logic [gadm_pkg::DZ_W-1:0]       dz;
   logic                            raw_neg;

   // capture the accepted word
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         is_axis_ff <= in_is_axis;
         axis_ff    <= in_axis;
         raw_ff     <= in_raw;
      end
   end

   // decode axis kind, deadzone test and excess over the deadzone
   always_comb begin
      raw_neg = raw_ff[gadm_pkg::RAW_W-1];
      kind_in = gadm_pkg::KIND_NONE;
      if (is_axis_ff) begin
         case (axis_ff)
            gadm_pkg::AXIS_LEFT_X,
            gadm_pkg::AXIS_LEFT_Y,
            gadm_pkg::AXIS_RIGHT_X,
            gadm_pkg::AXIS_RIGHT_Y:   kind_in = gadm_pkg::KIND_STICK;
            gadm_pkg::AXIS_LEFT_TRG,
            gadm_pkg::AXIS_RIGHT_TRG: kind_in = gadm_pkg::KIND_TRIG;
            gadm_pkg::AXIS_DPAD_H:    kind_in = gadm_pkg::KIND_DPAD_H;
            gadm_pkg::AXIS_DPAD_V:    kind_in = gadm_pkg::KIND_DPAD_V;
            default:                  kind_in = gadm_pkg::KIND_NONE;
         endcase
      end
      if (kind_in == gadm_pkg::KIND_TRIG) begin
         dz = cfg.trig_dz;
         // triggers ignore the negative half
         mag = raw_neg ? '0 : raw_ff;
      end else begin
         dz = cfg.stick_dz;
         // most negative raw gives a magnitude of full scale plus one
         mag = raw_neg ? gadm_pkg::RAW_W'(~raw_ff + 1'b1) : raw_ff;
      end
      live_in   = mag > {1'b0, dz};
      excess_in = mag - {1'b0, dz};
      den_in    = gadm_pkg::RAW_FULL - dz;
   end

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         kind_ff   <= kind_in;
         live_ff   <= live_in;
         neg_ff    <= raw_neg;
         excess_ff <= excess_in;
         den_ff    <= den_in;
      end
   end

   // scaled numerator with half the divisor for rounding
   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         num_ff <= gadm_pkg::NUM_W'(excess_ff) * gadm_pkg::NUM_W'(gadm_pkg::FULL_SCALE)
                   + gadm_pkg::NUM_W'(den_ff >> 1);
      end
   end

   assign status.need_div = live_ff && (den_ff != '0) &&
                            ((kind_ff == gadm_pkg::KIND_STICK) ||
                             (kind_ff == gadm_pkg::KIND_TRIG));
   assign status.div_last = cnt_ff == gadm_pkg::CNT_W'(gadm_pkg::QUO_W - 1);

   // restoring divider, one quotient bit per cycle
   always_comb begin
      trial  = {rem_ff[gadm_pkg::REM_W-2:0], quo_ff[gadm_pkg::QUO_W-1]};
      qbit   = trial >= {1'b0, den_ff};
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      if (cmd.setup) begin
         rem_in = {1'b0, num_ff[gadm_pkg::NUM_W-1:gadm_pkg::QUO_W]};
         quo_in = num_ff[gadm_pkg::QUO_W-1:0];
         cnt_in = '0;
      end else if (cmd.div_step) begin
         rem_in = qbit ? trial - {1'b0, den_ff} : trial;
         quo_in = {quo_ff[gadm_pkg::QUO_W-2:0], qbit};
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   // saturate, apply deadzone and sign
   always_comb begin
      if ((den_ff == '0) ||
          (quo_ff > gadm_pkg::QUO_W'(gadm_pkg::FULL_SCALE))) begin
         q_sat = gadm_pkg::FULL_SCALE;
      end else begin
         q_sat = quo_ff[gadm_pkg::FRAC_BITS-1:0];
      end
      q_mag = live_ff ? gadm_pkg::STICK_W'(q_sat) : '0;
      if ((kind_ff == gadm_pkg::KIND_STICK) && neg_ff) begin
         new_val = gadm_pkg::STICK_W'(~q_mag + 1'b1);
      end else begin
         new_val = q_mag;
      end
   end

   // d-pad pair update from the sign of the value
   always_comb begin
      dpad_in = dpad_ff;
      case (kind_ff)
         gadm_pkg::KIND_DPAD_H: begin
            if (neg_ff) begin
               dpad_in = (dpad_ff & ~gadm_pkg::DPAD_RIGHT) | gadm_pkg::DPAD_LEFT;
            end else if (raw_ff != '0) begin
               dpad_in = (dpad_ff & ~gadm_pkg::DPAD_LEFT) | gadm_pkg::DPAD_RIGHT;
            end else begin
               dpad_in = dpad_ff & ~(gadm_pkg::DPAD_LEFT | gadm_pkg::DPAD_RIGHT);
            end
         end
         gadm_pkg::KIND_DPAD_V: begin
            if (neg_ff) begin
               dpad_in = (dpad_ff & ~gadm_pkg::DPAD_DOWN) | gadm_pkg::DPAD_UP;
            end else if (raw_ff != '0) begin
               dpad_in = (dpad_ff & ~gadm_pkg::DPAD_UP) | gadm_pkg::DPAD_DOWN;
            end else begin
               dpad_in = dpad_ff & ~(gadm_pkg::DPAD_UP | gadm_pkg::DPAD_DOWN);
            end
         end
         default: begin
            dpad_in = dpad_ff;
         end
      endcase
   end

   // held snapshot
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < gadm_pkg::NUM_AXES; i++) begin
            axis_val_ff[i] <= '0;
         end
         dpad_ff <= '0;
      end else if (cmd.commit) begin
         if ((kind_ff == gadm_pkg::KIND_STICK) || (kind_ff == gadm_pkg::KIND_TRIG)) begin
            axis_val_ff[axis_ff[gadm_pkg::AIDX_W-1:0]] <= new_val;
         end
         dpad_ff <= dpad_in;
      end
   end

   assign snapshot.left_stick_x        = axis_val_ff[0];
   assign snapshot.left_stick_y        = axis_val_ff[1];
   assign snapshot.left_trigger_level  = axis_val_ff[2][gadm_pkg::TRIG_W-1:0];
   assign snapshot.right_stick_x       = axis_val_ff[3];
   assign snapshot.right_stick_y       = axis_val_ff[4];
   assign snapshot.right_trigger_level = axis_val_ff[5][gadm_pkg::TRIG_W-1:0];
   assign snapshot.dpad_bits           = dpad_ff;

endmodule

[hdl/gamepad_axis_deadzone_mapper_unit.sv]
// top level: configuration registers, stream ports and output word register
// stick and trigger events whose value lies beyond a deadzone below full scale pass
// through the serial divider between accept and rsp_tvalid; other events skip it
// throughput: one event at a time; the sequencer returns to idle, ready for the next word,
// when the result is loaded into the output register, which holds it until rsp_tready
// reset: synchronous, active high; clears the held axes and d-pad bits to zero,
// stick deadzone to 8000 and trigger deadzone to 400, and empties the output
module gamepad_axis_deadzone_mapper_unit (
   input  logic         clock,
   input  logic         reset,
   // input stream
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [23:0]  req_tdata,   // axis_number[7:0], raw_value[23:8]
   input  logic         req_tuser,   // is_axis_event
   // result stream
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // left_stick_x[15:0], left_stick_y[31:16], left_trigger_level[46:32],
   // right_stick_x[62:47], right_stick_y[78:63], right_trigger_level[93:79],
   // dpad_bits[97:94], zero fill[103:98]
   output logic [103:0] rsp_tdata,
   // configuration port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [gadm_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [gadm_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [gadm_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   gadm_pkg::cfg_type       cfg_ff, cfg_in;
   gadm_pkg::dp_cmd_type    cmd;
   gadm_pkg::dp_status_type status;
   gadm_pkg::snapshot_type  snapshot;
   gadm_pkg::snapshot_type  out_ff;
   logic                    out_valid_ff, out_valid_in;
   logic                    out_free;
   logic                    csr_write;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_paddr)
            gadm_pkg::ADDR_STICK_DZ: cfg_in.stick_dz = csr_pwdata[gadm_pkg::DZ_W-1:0];
            gadm_pkg::ADDR_TRIG_DZ:  cfg_in.trig_dz  = csr_pwdata[gadm_pkg::DZ_W-1:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stick_dz <= gadm_pkg::STICK_DZ_RESET;
         cfg_ff.trig_dz  <= gadm_pkg::TRIG_DZ_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // register read back
   always_comb begin
      case (csr_paddr)
         gadm_pkg::ADDR_STICK_DZ: csr_prdata = gadm_pkg::CSR_DATA_W'(cfg_ff.stick_dz);
         gadm_pkg::ADDR_TRIG_DZ:  csr_prdata = gadm_pkg::CSR_DATA_W'(cfg_ff.trig_dz);
         default:                 csr_prdata = '0;
      endcase
   end

   // sequencer
   assign out_free = !out_valid_ff || rsp_tready;

   gadm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .out_free   (out_free),
      .status     (status),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   gadm_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .cfg        (cfg_ff),
      .in_is_axis (req_tuser),
      .in_axis    (req_tdata[7:0]),
      .in_raw     (req_tdata[23:8]),
      .status     (status),
      .snapshot   (snapshot)
   );

   // output word register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.publish) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         out_ff <= snapshot;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'b0, out_ff};

endmodule
